@@ sv/sfbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sfbl_pkg: shared types for the sorted free block list
// command and status codes, compare modes and the table entry layout
// ----------------------------------------------------------------------------
package sfbl_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int DATA_W        = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIT    = 2'd2,
      CMD_LAST   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CMP_EQ = 2'd0,
      CMP_LE = 2'd1,
      CMP_GE = 2'd2
   } cmp_mode_type;

   // address in the low half, size in the high half
   typedef struct packed {
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] addr;
   } entry_type;

endpackage

@@ sv/sfbl_cmp.sv @@
// ----------------------------------------------------------------------------
// sfbl_cmp: shared compare unit
// one subtractor gives equal, less-or-equal and greater-or-equal tests
// ----------------------------------------------------------------------------
module sfbl_cmp (
   input  logic [sfbl_pkg::DATA_W-1:0] lhs,
   input  logic [sfbl_pkg::DATA_W-1:0] rhs,
   input  sfbl_pkg::cmp_mode_type      mode,
   output logic                        hit
);

   logic [sfbl_pkg::DATA_W:0] diff;
   logic                      lt;
   logic                      eq;

   assign diff = {1'b0, lhs} - {1'b0, rhs};
   assign lt   = diff[sfbl_pkg::DATA_W];
   assign eq   = (diff[sfbl_pkg::DATA_W-1:0] == '0);

   always_comb begin
      case (mode)
         sfbl_pkg::CMP_EQ: hit = eq;
         sfbl_pkg::CMP_LE: hit = lt | eq;
         sfbl_pkg::CMP_GE: hit = ~lt;
         default:          hit = 1'b0;
      endcase
   end

endmodule

@@ sv/sorted_free_block_list.sv @@
// ----------------------------------------------------------------------------
// sorted_free_block_list: size-ordered free block table with best-fit lookup
// table of address/size entries kept in ascending size, scanned slot by slot
// ----------------------------------------------------------------------------
// usage
// - req channel: one word per command; req_tuser is the command (insert,
//   remove by address, best fit, largest), req_tdata carries block_addr,
//   block_size and request_size
// - rsp channel: exactly one word per command; rsp_tuser is the status,
//   rsp_tdata carries found_addr and found_size (zero unless a query hit)
// - one command at a time: req_tready is high only while the sequencer idles
// - each slot step is a table read then a compare/write, through the one
//   read port and one write port of the table and the shared compare unit
// - insert: walks down from the top slot, moving each larger entry up one
//   slot, and writes the new block above the first entry no larger than it
//   (slot 0 if none); a full table answers with the full status, no scan
// - remove: search by address from slot 0, then shift down, or a miss
// - best fit: first entry from slot 0 whose size covers the request, else a
//   miss; largest: the top entry, or the empty status on an empty table
// - an output register holds the response; while rsp_tready is low the
//   finished response waits there and the next command may already be taken
//   and run, finishing once the register frees up
// - reset empties the table at once (entry count only, no clearing pass)
// ----------------------------------------------------------------------------
module sorted_free_block_list #(
   parameter int TABLE_DEPTH = sfbl_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // block_addr[31:0], block_size[63:32],
                                    // request_size[95:64]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // response words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // found_addr[31:0], found_size[63:32]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int DW    = sfbl_pkg::DATA_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD,
      S_EV,
      S_OUT
   } state_type;

   // sequencer state
   state_type               state_ff,      state_in;
   sfbl_pkg::cmd_type       cmd_ff,        cmd_in;
   logic [DW-1:0]           key_addr_ff,   key_addr_in;
   logic [DW-1:0]           key_size_ff,   key_size_in;
   logic [DW-1:0]           key_req_ff,    key_req_in;
   logic [CNT_W-1:0]        ptr_ff,        ptr_in;
   logic [CNT_W-1:0]        count_ff,      count_in;
   logic                    shift_ff,      shift_in;
   sfbl_pkg::status_type    res_status_ff, res_status_in;
   sfbl_pkg::entry_type     res_entry_ff,  res_entry_in;
   // output register
   logic                    rsp_valid_ff,  rsp_valid_in;
   sfbl_pkg::status_type    rsp_status_ff, rsp_status_in;
   sfbl_pkg::entry_type     rsp_entry_ff,  rsp_entry_in;

   // table memory
   sfbl_pkg::entry_type     slot_mem [TABLE_DEPTH];
   sfbl_pkg::entry_type     rd_entry_ff;
   logic [CNT_W-1:0]        rd_ptr;
   logic                    wr_en;
   logic [CNT_W-1:0]        wr_ptr;
   sfbl_pkg::entry_type     wr_entry;
   sfbl_pkg::entry_type     new_entry;

   // shared compare unit
   logic [DW-1:0]           cmp_lhs;
   logic [DW-1:0]           cmp_rhs;
   sfbl_pkg::cmp_mode_type  cmp_mode;
   logic                    cmp_hit;

   logic                    table_full;
   logic [CNT_W-1:0]        ptr_inc;
   logic [CNT_W-1:0]        ptr_dec;

   assign table_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign ptr_inc    = ptr_ff + CNT_W'(1);
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign new_entry  = '{size: key_size_ff, addr: key_addr_ff};

   // read slot: insert walks down from the top, remove shifts pull from above
   always_comb begin
      case (cmd_ff)
         sfbl_pkg::CMD_INSERT: rd_ptr = ptr_dec;
         sfbl_pkg::CMD_REMOVE: rd_ptr = shift_ff ? ptr_inc : ptr_ff;
         default:              rd_ptr = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_ptr[IDX_W-1:0]] <= wr_entry;
      end
      rd_entry_ff <= slot_mem[rd_ptr[IDX_W-1:0]];
   end

   // operand select for the compare unit
   always_comb begin
      case (cmd_ff)
         sfbl_pkg::CMD_INSERT: begin
            cmp_lhs  = rd_entry_ff.size;
            cmp_rhs  = key_size_ff;
            cmp_mode = sfbl_pkg::CMP_LE;
         end
         sfbl_pkg::CMD_REMOVE: begin
            cmp_lhs  = rd_entry_ff.addr;
            cmp_rhs  = key_addr_ff;
            cmp_mode = sfbl_pkg::CMP_EQ;
         end
         default: begin
            cmp_lhs  = rd_entry_ff.size;
            cmp_rhs  = key_req_ff;
            cmp_mode = sfbl_pkg::CMP_GE;
         end
      endcase
   end

   sfbl_cmp u_cmp (
      .lhs  (cmp_lhs),
      .rhs  (cmp_rhs),
      .mode (cmp_mode),
      .hit  (cmp_hit)
   );

   // table writes: new block lands, or an entry moves one slot
   always_comb begin
      wr_en    = 1'b0;
      wr_ptr   = ptr_ff;
      wr_entry = rd_entry_ff;
      if (state_ff == S_RD && cmd_ff == sfbl_pkg::CMD_INSERT && ptr_ff == '0) begin
         wr_en    = 1'b1;
         wr_entry = new_entry;
      end else if (state_ff == S_EV && cmd_ff == sfbl_pkg::CMD_INSERT) begin
         wr_en    = 1'b1;
         wr_entry = cmp_hit ? new_entry : rd_entry_ff;
      end else if (state_ff == S_EV && cmd_ff == sfbl_pkg::CMD_REMOVE && shift_ff) begin
         wr_en    = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_addr_in   = key_addr_ff;
      key_size_in   = key_size_ff;
      key_req_in    = key_req_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      shift_in      = shift_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in       = sfbl_pkg::cmd_type'(req_tuser);
               key_addr_in  = req_tdata[31:0];
               key_size_in  = req_tdata[63:32];
               key_req_in   = req_tdata[95:64];
               shift_in     = 1'b0;
               res_entry_in = '0;
               ptr_in       = '0;
               case (sfbl_pkg::cmd_type'(req_tuser))
                  sfbl_pkg::CMD_INSERT: begin
                     if (table_full) begin
                        res_status_in = sfbl_pkg::ST_FULL;
                        state_in      = S_OUT;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = S_RD;
                     end
                  end
                  sfbl_pkg::CMD_LAST: begin
                     if (count_ff == '0) begin
                        res_status_in = sfbl_pkg::ST_EMPTY;
                        state_in      = S_OUT;
                     end else begin
                        ptr_in   = count_ff - CNT_W'(1);
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_RD;
                  end
               endcase
            end
         end

         S_RD: begin
            case (cmd_ff)
               sfbl_pkg::CMD_INSERT: begin
                  if (ptr_ff == '0) begin
                     // everything shifted up, new block goes in slot 0
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = sfbl_pkg::ST_OK;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_EV;
                  end
               end
               sfbl_pkg::CMD_REMOVE: begin
                  if (shift_ff) begin
                     if (ptr_inc >= count_ff) begin
                        count_in      = count_ff - CNT_W'(1);
                        res_status_in = sfbl_pkg::ST_OK;
                        state_in      = S_OUT;
                     end else begin
                        state_in = S_EV;
                     end
                  end else if (ptr_ff >= count_ff) begin
                     res_status_in = sfbl_pkg::ST_MISS;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_EV;
                  end
               end
               sfbl_pkg::CMD_FIT: begin
                  if (ptr_ff >= count_ff) begin
                     res_status_in = sfbl_pkg::ST_MISS;
                     state_in      = S_OUT;
                  end else begin
                     state_in = S_EV;
                  end
               end
               default: begin
                  state_in = S_EV;
               end
            endcase
         end

         S_EV: begin
            case (cmd_ff)
               sfbl_pkg::CMD_INSERT: begin
                  if (cmp_hit) begin
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = sfbl_pkg::ST_OK;
                     state_in      = S_OUT;
                  end else begin
                     ptr_in   = ptr_dec;
                     state_in = S_RD;
                  end
               end
               sfbl_pkg::CMD_REMOVE: begin
                  if (shift_ff) begin
                     ptr_in   = ptr_inc;
                     state_in = S_RD;
                  end else if (cmp_hit) begin
                     // match found, close the gap from here up
                     shift_in = 1'b1;
                     state_in = S_RD;
                  end else begin
                     ptr_in   = ptr_inc;
                     state_in = S_RD;
                  end
               end
               sfbl_pkg::CMD_FIT: begin
                  if (cmp_hit) begin
                     res_status_in = sfbl_pkg::ST_OK;
                     res_entry_in  = rd_entry_ff;
                     state_in      = S_OUT;
                  end else begin
                     ptr_in   = ptr_inc;
                     state_in = S_RD;
                  end
               end
               default: begin
                  res_status_in = sfbl_pkg::ST_OK;
                  res_entry_in  = rd_entry_ff;
                  state_in      = S_OUT;
               end
            endcase
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         shift_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_addr_ff   <= key_addr_in;
      key_size_ff   <= key_size_in;
      key_req_ff    <= key_req_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + CNT_W'(1) || count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_OUT))
      else $error("response raised outside the output step");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == sfbl_pkg::ST_FULL || rsp_tuser == sfbl_pkg::ST_MISS ||
                      rsp_tuser == sfbl_pkg::ST_EMPTY)) |-> rsp_tdata == '0)
      else $error("nonzero payload on a failed command");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_ptr < CNT_W'(TABLE_DEPTH))
      else $error("table write past the last slot");
`endif

endmodule
